// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/i2cm_pkg.sv =====
package i2cm_pkg;

  // command codes
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  localparam int TPU_W = 10;
  localparam int TMO_W = 8;
  localparam logic [TPU_W-1:0] TPU_RESET = 10'd50;
  localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;
  localparam logic [7:0] MSB_MASK = 8'h80;

  // line sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WR_LO   = 5'd5,
    PH_WR_HI   = 5'd6,
    PH_WR_TL   = 5'd7,
    PH_RD_LO   = 5'd8,
    PH_RD_HI   = 5'd9,
    PH_AK_LO   = 5'd10,
    PH_AK_HI   = 5'd11,
    PH_WA_REL  = 5'd12,
    PH_WA_SCL  = 5'd13,
    PH_WA_POLL = 5'd14
  } phase_t;

  // one tick request, lowest field last
  typedef struct packed {
    logic       sda_in;
    logic       send_ack;
    logic [7:0] tx_data;
    logic [2:0] cmd;
  } item_t;

  // one tick result, lowest field last
  typedef struct packed {
    logic       ack_fail;
    logic [7:0] rx_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } result_t;

  // delay timer step
  typedef struct packed {
    logic [TPU_W-1:0] div;
    logic [2:0]       unit;
    logic             expired;
  } tmr_t;

  // microseconds a phase holds its levels
  function automatic logic [2:0] phase_us(input phase_t ph);
    logic [2:0] us;
    case (ph)
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: us = 3'd4;
      PH_WR_LO, PH_WR_HI, PH_WR_TL, PH_RD_LO: us = 3'd2;
      PH_AK_LO, PH_AK_HI: us = 3'd2;
      PH_RD_HI, PH_WA_REL, PH_WA_SCL: us = 3'd1;
      default: us = 3'd0;
    endcase
    return us;
  endfunction

endpackage

// ===== sv/i2cm_timer.sv =====
module i2cm_timer (
  input  logic [i2cm_pkg::TPU_W-1:0] ticks_per_us,
  input  logic [i2cm_pkg::TPU_W-1:0] div,
  input  logic [2:0]                 unit,
  input  logic [2:0]                 us,
  output i2cm_pkg::tmr_t             tmr
);
  import i2cm_pkg::*;

  logic [TPU_W:0] div_inc;
  logic [2:0]     unit_inc;

  assign div_inc  = {1'b0, div} + {{TPU_W{1'b0}}, 1'b1};
  assign unit_inc = unit + 3'd1;

  // a zero divisor behaves as one since the compare still wraps every tick
  always_comb begin
    tmr.div     = div_inc[TPU_W-1:0];
    tmr.unit    = unit;
    tmr.expired = 1'b0;
    if (div_inc >= {1'b0, ticks_per_us}) begin
      tmr.div  = '0;
      tmr.unit = unit_inc;
      if (unit_inc >= us) begin
        tmr.unit    = 3'd0;
        tmr.expired = 1'b1;
      end
    end
  end

endmodule

// ===== sv/i2cm_seq.sv =====
module i2cm_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  i2cm_pkg::item_t            item,
  input  logic [i2cm_pkg::TPU_W-1:0] ticks_per_us,
  input  logic [i2cm_pkg::TMO_W-1:0] ack_timeout,
  output i2cm_pkg::result_t          res
);
  import i2cm_pkg::*;
  `include "assert_macros.svh"

  phase_t           phase, phase_next;
  logic [3:0]       bit_count, bit_count_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic [TPU_W-1:0] tick_divider, tick_divider_next;
  logic [2:0]       unit_count, unit_count_next;
  logic [7:0]       poll_count, poll_count_next;
  logic             scl_level, scl_level_next;
  logic             sda_level, sda_level_next;
  logic [7:0]       rx_byte, rx_byte_next;
  logic             fail_flag, fail_flag_next;
  logic             ack_choice, ack_choice_next;
  logic             done;
  tmr_t             tmr;

  i2cm_timer u_timer (
    .ticks_per_us (ticks_per_us),
    .div          (tick_divider),
    .unit         (unit_count),
    .us           (phase_us(phase)),
    .tmr          (tmr)
  );

  // sequencer state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_reg    <= '0;
      tick_divider <= '0;
      unit_count   <= '0;
      poll_count   <= '0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      rx_byte      <= '0;
      fail_flag    <= 1'b0;
      ack_choice   <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_reg    <= shift_reg_next;
      tick_divider <= tick_divider_next;
      unit_count   <= unit_count_next;
      poll_count   <= poll_count_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      rx_byte      <= rx_byte_next;
      fail_flag    <= fail_flag_next;
      ack_choice   <= ack_choice_next;
    end
  end

  // next state and line levels for one tick
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    tick_divider_next = tick_divider;
    unit_count_next   = unit_count;
    poll_count_next   = poll_count;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    rx_byte_next      = rx_byte;
    fail_flag_next    = fail_flag;
    ack_choice_next   = ack_choice;
    done              = 1'b0;

    if (phase == PH_IDLE) begin
      // command launch, other codes are ignored
      if (item.cmd >= CMD_START && item.cmd <= CMD_WAIT_ACK) begin
        tick_divider_next = '0;
        unit_count_next   = '0;
        bit_count_next    = '0;
        case (item.cmd)
          CMD_START: begin
            scl_level_next = 1'b1;
            sda_level_next = 1'b1;
            phase_next     = PH_ST_A;
          end
          CMD_STOP: begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
            phase_next     = PH_SP_A;
          end
          CMD_WRITE: begin
            shift_reg_next = item.tx_data;
            scl_level_next = 1'b0;
            sda_level_next = |(item.tx_data & MSB_MASK);
            phase_next     = PH_WR_LO;
          end
          CMD_READ: begin
            shift_reg_next  = '0;
            ack_choice_next = item.send_ack;
            scl_level_next  = 1'b0;
            sda_level_next  = 1'b1;
            phase_next      = PH_RD_LO;
          end
          default: begin
            fail_flag_next  = 1'b0;
            poll_count_next = '0;
            sda_level_next  = 1'b1;
            phase_next      = PH_WA_REL;
          end
        endcase
      end
    end else if (phase == PH_WA_POLL) begin
      // ack poll, one sample per tick
      if (!item.sda_in) begin
        scl_level_next = 1'b0;
        phase_next     = PH_IDLE;
        done           = 1'b1;
      end else if (poll_count >= ack_timeout) begin
        fail_flag_next    = 1'b1;
        tick_divider_next = '0;
        unit_count_next   = '0;
        scl_level_next    = 1'b0;
        sda_level_next    = 1'b0;
        phase_next        = PH_SP_A;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else begin
      // timed phases
      tick_divider_next = tmr.div;
      unit_count_next   = tmr.unit;
      if (tmr.expired) begin
        case (phase)
          PH_ST_A: begin
            sda_level_next = 1'b0;
            phase_next     = PH_ST_B;
          end
          PH_ST_B: begin
            scl_level_next = 1'b0;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end
          PH_SP_A: begin
            scl_level_next = 1'b1;
            sda_level_next = 1'b1;
            phase_next     = PH_SP_B;
          end
          PH_SP_B: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_WR_LO: begin
            scl_level_next = 1'b1;
            phase_next     = PH_WR_HI;
          end
          PH_WR_HI: begin
            scl_level_next = 1'b0;
            phase_next     = PH_WR_TL;
          end
          PH_WR_TL: begin
            bit_count_next = bit_count + 4'd1;
            if (bit_count_next >= 4'd8) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              sda_level_next = shift_reg[6];
              phase_next     = PH_WR_LO;
            end
          end
          PH_RD_LO: begin
            scl_level_next = 1'b1;
            shift_reg_next = {shift_reg[6:0], item.sda_in};
            bit_count_next = bit_count + 4'd1;
            phase_next     = PH_RD_HI;
          end
          PH_RD_HI: begin
            scl_level_next = 1'b0;
            if (bit_count >= 4'd8) begin
              sda_level_next = ~ack_choice;
              phase_next     = PH_AK_LO;
            end else begin
              phase_next = PH_RD_LO;
            end
          end
          PH_AK_LO: begin
            scl_level_next = 1'b1;
            phase_next     = PH_AK_HI;
          end
          PH_AK_HI: begin
            scl_level_next = 1'b0;
            rx_byte_next   = shift_reg;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end
          PH_WA_REL: begin
            scl_level_next = 1'b1;
            phase_next     = PH_WA_SCL;
          end
          PH_WA_SCL: phase_next = PH_WA_POLL;
          default:   phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // result of this tick
  always_comb begin
    res.scl_release = scl_level_next;
    res.sda_release = sda_level_next;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.rx_data     = rx_byte_next;
    res.ack_fail    = fail_flag_next;
  end

  // bit counter never runs past one byte
  `ASSERT_ALWAYS(a_bit_count_range, clk, rst, bit_count <= 4'd8)
  // delay unit counter stays below the longest phase
  `ASSERT_ALWAYS(a_unit_count_range, clk, rst, unit_count < 3'd4)
  // state only moves on an accepted tick
  `ASSERT_NEXT(a_phase_holds, clk, rst, !fire, $stable(phase) && $stable(tick_divider))

endmodule

// ===== sv/i2c_master_bit_engine_top.sv =====
// channel | direction | tdata fields, lowest bit first
// s_*     | in        | cmd[2:0] tx_data[10:3] send_ack[11] sda_in[12]
// m_*     | out       | scl_release[0] sda_release[1] busy_res[2] done_res[3]
//         |           | rx_data[11:4] ack_fail[12]
// cfg_*   | in        | index 0 ticks_per_us, index 1 ack_timeout
//
// one request per cycle sustained while the output is not stalled; each request is one sequencer tick
// a request waits in the input register until it fires, and the output register
// captures its result as it fires
// rst is synchronous: line levels released, sequencer idle, config defaults
// an output stall holds the result and the input register, s_tready drops
// only when both are full
module i2c_master_bit_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // cmd, tx_data, send_ack, sda_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_release, sda_release, busy_res, done_res,
                                 // rx_data, ack_fail
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import i2cm_pkg::*;

  logic             in_valid;
  item_t            in_item;
  logic             fire;
  result_t          res;
  logic [TPU_W-1:0] ticks_per_us;
  logic [TMO_W-1:0] ack_timeout;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TPU_RESET;
      ack_timeout  <= TMO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_US: ticks_per_us <= cfg_wdata;
        CFG_ACK_TIMEOUT:  ack_timeout  <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= item_t'(s_tdata[12:0]);
    end
  end

  i2cm_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (in_item),
    .ticks_per_us (ticks_per_us),
    .ack_timeout  (ack_timeout),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, res};
    end
  end

endmodule

// ===== verif/i2c_master_bit_engine_top_tb.sv =====
`timescale 1ns / 100ps

module i2c_master_bit_engine_top_tb;
  import i2cm_pkg::*;

  // reserved command codes the sequencer must ignore
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;
  localparam int HOLD_CYCLES = 300;

  // tracks the expected line levels tick by tick and checks each result
  class i2c_line_checker;
    logic [9:0] tpu;
    logic [7:0] tmo;
    phase_t     ph;
    logic [3:0] bits;
    logic [7:0] shreg;
    logic [9:0] div;
    logic [2:0] units;
    logic [7:0] polls;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       fail;
    logic       ack_sel;
    result_t    levels_q[$];
    int n_req, n_done, n_timeouts, n_reads, n_checked, n_errors;

    function new();
      tpu = TPU_RESET;
      tmo = TMO_RESET;
      ph = PH_IDLE;
      bits = '0;
      shreg = '0;
      div = '0;
      units = '0;
      polls = '0;
      scl = 1'b1;
      sda = 1'b1;
      rx = '0;
      fail = 1'b0;
      ack_sel = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [9:0] val);
      if (idx == CFG_TICKS_PER_US) tpu = val;
      else tmo = val[7:0];
    endfunction

    // microseconds each timed phase holds its levels
    function logic [2:0] hold_us(phase_t p);
      case (p)
        PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: return 3'd4;
        PH_RD_HI, PH_WA_REL, PH_WA_SCL: return 3'd1;
        PH_IDLE, PH_WA_POLL: return 3'd0;
        default: return 3'd2;
      endcase
    endfunction

    // one tick of the delay counter, zero ticks_per_us behaves as one
    function bit delay_done(logic [2:0] us);
      if ({1'b0, div} + 11'd1 >= {1'b0, tpu}) begin
        div = '0;
        units = units + 3'd1;
        if (units >= us) begin
          units = '0;
          return 1'b1;
        end
      end else begin
        div = div + 10'd1;
      end
      return 1'b0;
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function bit polling();
      return ph == PH_WA_POLL;
    endfunction

    function int pending();
      return levels_q.size();
    endfunction

    // advance one tick and queue the levels it leaves behind
    function void note_request(item_t it);
      result_t r;
      logic fin;
      fin = 1'b0;
      n_req++;
      if (ph == PH_IDLE) begin
        if (it.cmd >= CMD_START && it.cmd <= CMD_WAIT_ACK) begin
          div = '0;
          units = '0;
          bits = '0;
          case (it.cmd)
            CMD_START: begin
              scl = 1'b1; sda = 1'b1; ph = PH_ST_A;
            end
            CMD_STOP: begin
              scl = 1'b0; sda = 1'b0; ph = PH_SP_A;
            end
            CMD_WRITE: begin
              shreg = it.tx_data; scl = 1'b0; sda = it.tx_data[7]; ph = PH_WR_LO;
            end
            CMD_READ: begin
              shreg = '0; ack_sel = it.send_ack; scl = 1'b0; sda = 1'b1; ph = PH_RD_LO;
            end
            default: begin
              fail = 1'b0; polls = '0; sda = 1'b1; ph = PH_WA_REL;
            end
          endcase
        end
      end else if (ph == PH_WA_POLL) begin
        // ack seen, timeout turns into a stop, else keep polling
        if (!it.sda_in) begin
          scl = 1'b0; ph = PH_IDLE; fin = 1'b1;
        end else if (polls >= tmo) begin
          fail = 1'b1;
          n_timeouts++;
          div = '0;
          units = '0;
          scl = 1'b0; sda = 1'b0; ph = PH_SP_A;
        end else begin
          polls = polls + 8'd1;
        end
      end else if (delay_done(hold_us(ph))) begin
        case (ph)
          PH_ST_A: begin sda = 1'b0; ph = PH_ST_B; end
          PH_ST_B: begin scl = 1'b0; ph = PH_IDLE; fin = 1'b1; end
          PH_SP_A: begin scl = 1'b1; sda = 1'b1; ph = PH_SP_B; end
          PH_SP_B: begin ph = PH_IDLE; fin = 1'b1; end
          PH_WR_LO: begin scl = 1'b1; ph = PH_WR_HI; end
          PH_WR_HI: begin scl = 1'b0; ph = PH_WR_TL; end
          PH_WR_TL: begin
            bits = bits + 4'd1;
            if (bits >= 4'd8) begin
              ph = PH_IDLE; fin = 1'b1;
            end else begin
              shreg = shreg << 1; sda = shreg[7]; ph = PH_WR_LO;
            end
          end
          PH_RD_LO: begin
            scl = 1'b1;
            shreg = {shreg[6:0], it.sda_in};
            bits = bits + 4'd1;
            ph = PH_RD_HI;
          end
          PH_RD_HI: begin
            scl = 1'b0;
            if (bits >= 4'd8) begin
              sda = !ack_sel; ph = PH_AK_LO;
            end else begin
              ph = PH_RD_LO;
            end
          end
          PH_AK_LO: begin scl = 1'b1; ph = PH_AK_HI; end
          PH_AK_HI: begin
            scl = 1'b0; rx = shreg; ph = PH_IDLE; fin = 1'b1; n_reads++;
          end
          PH_WA_REL: begin scl = 1'b1; ph = PH_WA_SCL; end
          PH_WA_SCL: ph = PH_WA_POLL;
          default: ph = PH_IDLE;
        endcase
      end
      if (fin) n_done++;
      r.scl_release = scl;
      r.sda_release = sda;
      r.busy_res = (ph != PH_IDLE);
      r.done_res = fin;
      r.rx_data = rx;
      r.ack_fail = fail;
      levels_q.push_back(r);
    endfunction

    function void field_check(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
        $error("%s expected %0h got %0h", name, want_v, got_v);
        n_errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (levels_q.size() == 0) begin
        $error("result %h with no request outstanding", got);
        n_errors++;
        return;
      end
      want = levels_q.pop_front();
      n_checked++;
      field_check("scl_release", want.scl_release, got.scl_release);
      field_check("sda_release", want.sda_release, got.sda_release);
      field_check("busy_res", want.busy_res, got.busy_res);
      field_check("done_res", want.done_res, got.done_res);
      field_check("rx_data", want.rx_data, got.rx_data);
      field_check("ack_fail", want.ack_fail, got.ack_fail);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [9:0]  cfg_wdata;

  logic steady;
  logic hold_off;
  int   n_cmds;
  i2c_line_checker sb;

  i2c_master_bit_engine_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one tick request, with random gaps, and wait for its acceptance
  task automatic drive_tick(input item_t it);
    while (!steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= 16'(it);
    do @(posedge clk); while (!s_tready);
    sb.note_request(it);
  endtask

  // issue a command while idle, then keep ticking until it finishes
  task automatic run_cmd(input logic [2:0] code, input logic [7:0] tx_val,
                         input logic ack_val, input int low_pct);
    item_t it;
    it.cmd = code;
    it.tx_data = tx_val;
    it.send_ack = ack_val;
    it.sda_in = 1'($urandom_range(1));
    if (code >= CMD_START && code <= CMD_WAIT_ACK) n_cmds++;
    drive_tick(it);
    while (sb.busy()) begin
      // occasional commands while busy must be ignored
      it.cmd = ($urandom_range(99) < 10) ? 3'($urandom_range(7)) : CMD_NONE;
      it.tx_data = 8'($urandom);
      it.send_ack = 1'($urandom_range(1));
      if (sb.polling()) it.sda_in = ($urandom_range(99) >= low_pct);
      else it.sda_in = 1'($urandom_range(1));
      drive_tick(it);
    end
  endtask

  task automatic rand_cmd(input logic [2:0] code);
    int pick;
    int low_pct;
    pick = $urandom_range(3);
    low_pct = (pick == 0) ? 0 : (pick == 1) ? 3 : (pick == 2) ? 50 : 100;
    run_cmd(code, 8'($urandom), 1'($urandom_range(1)), low_pct);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [9:0] tpu_v, input logic [7:0] tmo_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TICKS_PER_US;
    cfg_wdata <= tpu_v;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= 10'(tmo_v);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_TICKS_PER_US, tpu_v);
    sb.set_reg(CFG_ACK_TIMEOUT, 10'(tmo_v));
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 33);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[12:0]));
  end

  initial begin
    #200_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int target;
    logic [9:0] tpu_v;
    logic [7:0] tmo_v;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    steady = 1'b0;
    hold_off = 1'b0;
    n_cmds = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed at reset settings: ignored codes and a quick ack
    run_cmd(CMD_RSVD_6, 8'hFF, 1'b1, 50);
    run_cmd(CMD_RSVD_7, 8'h00, 1'b0, 50);
    run_cmd(CMD_NONE, 8'hFF, 1'b1, 50);
    run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100);

    // zero ticks_per_us acts as one, zero timeout gives up on first high poll
    drain();
    configure(10'd0, 8'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, 50);
    run_cmd(CMD_WRITE, 8'hA5, 1'b0, 50);
    run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 0);
    run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, 100);
    run_cmd(CMD_READ, 8'h00, 1'b1, 50);
    run_cmd(CMD_STOP, 8'h00, 1'b0, 50);

    // random phases: any code, one with a long output hold-off, one without gaps
    for (int k = 0; k < 3; k++) begin
      drain();
      tpu_v = (k == 1) ? 10'd1 : 10'($urandom_range(1));
      tmo_v = 8'($urandom_range(3));
      configure(tpu_v, tmo_v);
      steady = (k == 2);
      if (k == 1) hold_off = 1'b1;
      target = sb.n_req + ((k == 2) ? 60 : 50);
      while (sb.n_req < target) begin
        rand_cmd(3'($urandom_range(7)));
      end
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d ticks and %0d commands over five register settings",
             sb.n_req, n_cmds);
    $display("%0d commands finished, %0d reads, %0d wait-ack timeouts, %0d results checked",
             sb.n_done, sb.n_reads, sb.n_timeouts, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_timer.sv
sv/i2cm_seq.sv
sv/i2c_master_bit_engine_top.sv
verif/i2c_master_bit_engine_top_tb.sv
